@@ sv/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants
// Register indexes, field widths, the result record and the color table.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int NUM_COLORS  = 7;
  localparam int SAMPLE_BITS = 10;
  localparam int COLOR_W     = $clog2(NUM_COLORS);
  localparam int MS_W        = 16;
  localparam int THR_W       = 10;
  localparam int LEVEL_W     = 8;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  localparam logic [MS_W-1:0]    SAMPLE_WINDOW_RST = MS_W'(250);
  localparam logic [MS_W-1:0]    CLAP_WINDOW_RST   = MS_W'(500);
  localparam logic [THR_W-1:0]   CLAP_THRESHOLD_RST = THR_W'(921);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_WINDOW = 2'd0,
    REG_CLAP_WINDOW   = 2'd1,
    REG_CLAP_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_TICK   = 1'b1
  } item_mode_t;

  // Events raised by the window tracker for the clap logic
  typedef struct packed {
    logic done;
    logic clap;
  } win_ev_t;

  // Result record, first field in the highest bits
  typedef struct packed {
    logic                   clap_seen;
    logic [9:0]             peak_to_peak;
    logic                   window_done;
    logic [2:0]             color_index;
    logic                   lamp_on;
    logic [LEVEL_W-1:0]     blue_level;
    logic [LEVEL_W-1:0]     green_level;
    logic [LEVEL_W-1:0]     red_level;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } rgb_t;

  // Seven colors, repeated for table indexes past index 6
  function automatic rgb_t palette(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0, 4'd7, 4'd14: c = '{8'hFF, 8'hFF, 8'hFF};
      4'd1, 4'd8, 4'd15: c = '{8'hFF, 8'hFF, 8'h00};
      4'd2, 4'd9:        c = '{8'hFF, 8'h00, 8'h00};
      4'd3, 4'd10:       c = '{8'hFF, 8'h00, 8'hFF};
      4'd4, 4'd11:       c = '{8'h00, 8'hFF, 8'hFF};
      4'd5, 4'd12:       c = '{8'h00, 8'hFF, 8'h00};
      4'd6, 4'd13:       c = '{8'h00, 8'h00, 8'hFF};
      default:           c = '{8'hFF, 8'hFF, 8'hFF};
    endcase
    return c;
  endfunction

endpackage

@@ sv/csc_window.sv @@
// ----------------------------------------------------------------------------
// csc_window: sampling window tracker
// Running max/min over a window of ticks, peak-to-peak span and clap flag.
// ----------------------------------------------------------------------------
module csc_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                mode,
  input  logic [csc_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic [csc_pkg::MS_W-1:0]            sample_window_ms,
  input  logic [csc_pkg::THR_W-1:0]           clap_threshold,
  output csc_pkg::win_ev_t                    ev,
  output logic [csc_pkg::SAMPLE_BITS-1:0]     span_next
);
  import csc_pkg::*;

  localparam logic [SAMPLE_BITS:0] MIN_EMPTY = (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] window_max, window_max_next;
  logic [SAMPLE_BITS:0]   window_min, window_min_next;
  logic [MS_W-1:0]        window_elapsed, window_elapsed_next;
  logic [SAMPLE_BITS-1:0] held_span;
  logic [MS_W-1:0]        elapsed_bump;
  logic [SAMPLE_BITS-1:0] span;

  assign elapsed_bump = (window_elapsed == '1) ? window_elapsed : window_elapsed + 1'b1;
  // Empty window leaves min above max: span is zero
  assign span = ({1'b0, window_max} >= window_min)
              ? window_max - window_min[SAMPLE_BITS-1:0] : '0;

  always_comb begin
    window_max_next     = window_max;
    window_min_next     = window_min;
    window_elapsed_next = window_elapsed;
    span_next           = held_span;
    ev                  = '0;
    if (accept) begin
      if (mode == MODE_SAMPLE) begin
        // Samples arriving after the window end are dropped
        if (window_elapsed < sample_window_ms) begin
          if (sample > window_max) window_max_next = sample;
          if ({1'b0, sample} < window_min) window_min_next = {1'b0, sample};
        end
      end else begin
        window_elapsed_next = elapsed_bump;
        if (elapsed_bump >= sample_window_ms) begin
          ev.done             = 1'b1;
          window_elapsed_next = '0;
          span_next           = span;
          window_max_next     = '0;
          window_min_next     = MIN_EMPTY;
          // Compare at full span width against the zero-extended threshold
          ev.clap             = (MS_W'(span) > MS_W'(clap_threshold));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max     <= '0;
      window_min     <= MIN_EMPTY;
      window_elapsed <= '0;
      held_span      <= '0;
    end else begin
      window_max     <= window_max_next;
      window_min     <= window_min_next;
      window_elapsed <= window_elapsed_next;
      held_span      <= span_next;
    end
  end

endmodule

@@ sv/csc_lamp.sv @@
// ----------------------------------------------------------------------------
// csc_lamp: clap counter and lamp state
// Counts claps in the clap window, toggles the lamp or steps the color.
// ----------------------------------------------------------------------------
module csc_lamp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  csc_pkg::win_ev_t              ev,
  input  logic [csc_pkg::MS_W-1:0]      clap_window_ms,
  output logic                          lit_next,
  output logic [csc_pkg::COLOR_W-1:0]   color_next
);
  import csc_pkg::*;

  localparam logic [COLOR_W-1:0] COLOR_LAST = COLOR_W'(NUM_COLORS - 1);

  logic [MS_W-1:0]    clap_elapsed, clap_elapsed_next, ce_bump, ce_mid;
  logic [COUNT_W-1:0] clap_count, clap_count_next, count_mid;
  logic [COLOR_W-1:0] color_sel;
  logic               lit;

  assign ce_bump = (clap_elapsed == '1) ? clap_elapsed : clap_elapsed + 1'b1;

  always_comb begin
    clap_elapsed_next = clap_elapsed;
    clap_count_next   = clap_count;
    lit_next          = lit;
    color_next        = color_sel;
    ce_mid            = ce_bump;
    count_mid         = clap_count;
    if (ev.clap) begin
      // First clap restarts the clap window
      if (clap_count == '0) ce_mid = '0;
      if (clap_count != COUNT_MAX) count_mid = clap_count + 1'b1;
    end
    if (tick) begin
      clap_elapsed_next = ce_mid;
      clap_count_next   = count_mid;
      if (ce_mid > clap_window_ms) begin
        clap_elapsed_next = '0;
        clap_count_next   = '0;
        if (count_mid == COUNT_W'(2)) begin
          lit_next = ~lit;
        end else if (count_mid == COUNT_W'(1) && lit) begin
          color_next = (color_sel >= COLOR_LAST) ? '0 : color_sel + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clap_elapsed <= '0;
      clap_count   <= '0;
      color_sel    <= '0;
      lit          <= 1'b1;
    end else begin
      clap_elapsed <= clap_elapsed_next;
      clap_count   <= clap_count_next;
      color_sel    <= color_next;
      lit          <= lit_next;
    end
  end

endmodule

@@ sv/clap_switch_color_cycler_top.sv @@
// ----------------------------------------------------------------------------
// clap_switch_color_cycler_top: sound-activated RGB lamp control
// Peak-to-peak clap detection over tick-timed windows driving a color lamp.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_t*     | in  | tuser: mode (0 sample, 1 tick); tdata: sample [9:0]
//  m_t*     | out | tdata: red, green, blue, lamp_on, color_index,
//           |     |        window_done, peak_to_peak, clap_seen
//  cfg_*    | in  | write enable, register index, 16-bit data
//
//  Each item's state update is one pass of short logic into the state and
//  result registers, so the rate is one item/cycle while s_tready is high.
//  A result loads the main output register, or skid while that is held.
//  A two-entry output stage (result + skid) keeps s_tready high while one
//  result waits; s_tready drops only when both entries are full.
//  rst is synchronous: lamp on, white, empty windows, registers at defaults.
// ----------------------------------------------------------------------------
module clap_switch_color_cycler_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [csc_pkg::IN_DATA_W-1:0]        s_tdata,   // sample[9:0], zero pad
  input  logic                                 s_tuser,   // mode
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // red[7:0], green[15:8], blue[23:16], lamp_on[24], color_index[27:25],
  // window_done[28], peak_to_peak[38:29], clap_seen[39]
  output logic [csc_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                 cfg_we,
  input  logic [csc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import csc_pkg::*;

  // Configuration registers
  logic [MS_W-1:0]  sample_window_ms;
  logic [MS_W-1:0]  clap_window_ms;
  logic [THR_W-1:0] clap_threshold;

  logic                   accept;
  logic                   tick;
  win_ev_t                ev;
  logic [SAMPLE_BITS-1:0] span_next;
  logic                   lit_next;
  logic [COLOR_W-1:0]     color_next;
  logic [3:0]             color_idx16;
  rgb_t                   rgb;
  result_t                res;

  // Output stage: main register plus skid entry
  result_t out_q, skid_q;
  logic    out_valid, skid_valid;

  assign accept   = s_tvalid && s_tready;
  assign tick     = accept && (s_tuser == MODE_TICK);
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window_ms <= SAMPLE_WINDOW_RST;
      clap_window_ms   <= CLAP_WINDOW_RST;
      clap_threshold   <= CLAP_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_WINDOW:  sample_window_ms <= cfg_data;
        REG_CLAP_WINDOW:    clap_window_ms   <= cfg_data;
        REG_CLAP_THRESHOLD: clap_threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  csc_window u_window (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .mode             (s_tuser),
    .sample           (s_tdata[SAMPLE_BITS-1:0]),
    .sample_window_ms (sample_window_ms),
    .clap_threshold   (clap_threshold),
    .ev               (ev),
    .span_next        (span_next)
  );

  csc_lamp u_lamp (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .ev             (ev),
    .clap_window_ms (clap_window_ms),
    .lit_next       (lit_next),
    .color_next     (color_next)
  );

  // Build the result from the post-update state
  assign color_idx16 = 4'(color_next);
  assign rgb         = palette(color_idx16);

  always_comb begin
    res              = '0;
    res.red_level    = lit_next ? rgb.r : '0;
    res.green_level  = lit_next ? rgb.g : '0;
    res.blue_level   = lit_next ? rgb.b : '0;
    res.lamp_on      = lit_next;
    res.color_index  = color_idx16[2:0];
    res.window_done  = ev.done;
    res.peak_to_peak = 10'(span_next);
    res.clap_seen    = ev.clap;
  end

  // Load the main register when it is empty or draining, else park in skid;
  // refill the main register from skid when it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= accept;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_q <= skid_q;
        if (accept) skid_q <= res;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  // Skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without main result");

  // A dark lamp drives all PWM levels to zero
  a_dark_levels: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[24]) |-> (m_tdata[23:0] == '0))
    else $error("levels nonzero while lamp off");

  // A clap is only reported on a tick that closed a window
  a_clap_on_close: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39]) |-> m_tdata[28])
    else $error("clap without window close");

  // Stalled output holds while a result waits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_q)))
    else $error("pending result changed under stall");

endmodule
